/* rtl/core/sas_pkg.sv */
// shared types and constants for the score sorter with truncated mean
// no dependencies; used by sas_sorter and sort_and_average_scores
package sas_pkg;

  localparam int unsigned SCORE_BITS = 16;

  typedef struct packed {
    logic [SCORE_BITS-1:0] score;
    logic                  last;
  } item_t;

  typedef struct packed {
    logic [SCORE_BITS-1:0] sorted_score;
    logic [SCORE_BITS-1:0] average;
    logic                  overflow;
    logic                  end_of_run;
  } result_t;

  // control from the top sequencer to the sorter
  typedef struct packed {
    logic load;
    logic start;
  } sort_ctrl_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_START,
    ST_WAIT,
    ST_READ,
    ST_LOAD
  } top_state_t;

  typedef enum logic [2:0] {
    SRT_IDLE,
    SRT_FIRST,
    SRT_LOAD,
    SRT_STEP,
    SRT_TAIL
  } sort_state_t;

endpackage

/* rtl/core/sas_divider.sv */
// restoring divider, one quotient bit per cycle
// depends on nothing but its parameters; used by sort_and_average_scores
module sas_divider #(
  parameter int unsigned NUM_W = 22,
  parameter int unsigned DEN_W = 7,
  parameter int unsigned QUO_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [QUO_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  // numerator bits shift out at the top while quotient bits shift in below
  logic [NUM_W-1:0] work;

  logic [DEN_W:0] shifted;
  logic [DEN_W:0] diff;
  logic           ge;

  always_comb begin
    shifted = {rem, work[NUM_W-1]};
    ge      = shifted >= {1'b0, den};
    diff    = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt  <= cnt - CNT_W'(1);
      busy <= cnt != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      den  <= divisor;
    end else if (busy) begin
      rem  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      work <= {work[NUM_W-2:0], ge};
    end
  end

  assign quotient = work[QUO_W-1:0];

endmodule

/* rtl/core/sas_sorter.sv */
// score store with an in-place bubble sort over a single compare unit
// depends on sas_pkg; used by sort_and_average_scores
module sas_sorter #(
  parameter int unsigned MAX_SCORES = 64,
  parameter int unsigned AW = 6,
  parameter int unsigned CW = 7
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sas_pkg::sort_ctrl_t              ctrl,
  input  logic [AW-1:0]                    load_addr,
  input  logic [sas_pkg::SCORE_BITS-1:0]   load_data,
  input  logic [CW-1:0]                    n,
  input  logic [AW-1:0]                    emit_addr,
  output logic [sas_pkg::SCORE_BITS-1:0]   rd_data,
  output logic                             busy
);

  localparam int unsigned DW = sas_pkg::SCORE_BITS;

  logic [DW-1:0] mem [MAX_SCORES];

  sas_pkg::sort_state_t state, state_next;
  logic [AW-1:0] last_idx, last_idx_next;
  logic [AW-1:0] j, j_next;
  logic [DW-1:0] carry, carry_next;

  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  logic [DW-1:0] wd;

  // each pass carries the larger value forward and writes the smaller one back
  always_comb begin
    state_next    = state;
    last_idx_next = last_idx;
    j_next        = j;
    carry_next    = carry;
    rd_addr       = emit_addr;
    we            = 1'b0;
    wa            = load_addr;
    wd            = load_data;
    case (state)
      sas_pkg::SRT_IDLE: begin
        we = ctrl.load;
        if (ctrl.start && n > CW'(1)) begin
          last_idx_next = AW'(n - CW'(1));
          state_next    = sas_pkg::SRT_FIRST;
        end
      end
      sas_pkg::SRT_FIRST: begin
        rd_addr    = '0;
        state_next = sas_pkg::SRT_LOAD;
      end
      sas_pkg::SRT_LOAD: begin
        carry_next = rd_data;
        rd_addr    = AW'(1);
        j_next     = AW'(1);
        state_next = sas_pkg::SRT_STEP;
      end
      sas_pkg::SRT_STEP: begin
        we      = 1'b1;
        wa      = j - AW'(1);
        rd_addr = j + AW'(1);
        if (carry > rd_data) begin
          wd = rd_data;
        end else begin
          wd         = carry;
          carry_next = rd_data;
        end
        if (j == last_idx) begin
          state_next = sas_pkg::SRT_TAIL;
        end else begin
          j_next = j + AW'(1);
        end
      end
      sas_pkg::SRT_TAIL: begin
        we      = 1'b1;
        wa      = last_idx;
        wd      = carry;
        rd_addr = '0;
        if (last_idx == AW'(1)) begin
          state_next = sas_pkg::SRT_IDLE;
        end else begin
          last_idx_next = last_idx - AW'(1);
          state_next    = sas_pkg::SRT_LOAD;
        end
      end
      default: state_next = sas_pkg::SRT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sas_pkg::SRT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    last_idx <= last_idx_next;
    j        <= j_next;
    carry    <= carry_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  assign busy = state != sas_pkg::SRT_IDLE;

endmodule

/* rtl/core/sort_and_average_scores.sv */
// Score sorter with truncated mean.
// Requests arrive on item (score in Q8.8 plus a last flag) with item_valid and
// item_ready; item_ready is high while scores are being collected, one request
// per cycle. Each score is stored and added to a running sum. Scores beyond
// MAX_SCORES are dropped and set the overflow flag of the set.
// The request flagged last closes the set. The stored scores are then bubble
// sorted in place by one compare unit against a store with one write and one
// read port; pass e (e = n-1 down to 1) moves the largest of entries 0 to e
// into entry e. The mean comes from a restoring divider, one bit per cycle
// over the sum width, which runs alongside the sort. Results then leave on
// result in ascending order, each read in ST_READ and loaded in ST_LOAD, all
// with the same average and overflow; end_of_run marks the final one. A
// stalled receiver holds the output register and the sequencer waits on it.
// After the final result has been loaded the block is ready for the next set
// while that result is taken. Synchronous reset returns the sequencer to
// collecting with an empty set; the score store keeps its contents.
// depends on sas_pkg, sas_sorter and sas_divider
module sort_and_average_scores #(
  parameter int unsigned MAX_SCORES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  sas_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output sas_pkg::result_t result
);

  localparam int unsigned AW = $clog2(MAX_SCORES);
  localparam int unsigned CW = $clog2(MAX_SCORES + 1);
  localparam int unsigned SW = sas_pkg::SCORE_BITS + CW;

  sas_pkg::top_state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [SW-1:0] sum, sum_next;
  logic          dropped, dropped_next;
  logic [CW-1:0] idx, idx_next;
  logic          result_valid_next;
  sas_pkg::result_t result_next;

  sas_pkg::sort_ctrl_t            sort_ctrl;
  logic                           sort_busy;
  logic [AW-1:0]                  emit_addr;
  logic [sas_pkg::SCORE_BITS-1:0] rd_data;
  logic                           div_start;
  logic                           div_busy;
  logic [sas_pkg::SCORE_BITS-1:0] quotient;
  logic                           load_result;

  sas_sorter #(
    .MAX_SCORES(MAX_SCORES),
    .AW(AW),
    .CW(CW)
  ) u_sorter (
    .clk(clk),
    .rst(rst),
    .ctrl(sort_ctrl),
    .load_addr(count[AW-1:0]),
    .load_data(item.score),
    .n(count),
    .emit_addr(emit_addr),
    .rd_data(rd_data),
    .busy(sort_busy)
  );

  sas_divider #(
    .NUM_W(SW),
    .DEN_W(CW),
    .QUO_W(sas_pkg::SCORE_BITS)
  ) u_divider (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(sum),
    .divisor(count),
    .busy(div_busy),
    .quotient(quotient)
  );

  always_comb begin
    state_next        = state;
    count_next        = count;
    sum_next          = sum;
    dropped_next      = dropped;
    idx_next          = idx;
    result_valid_next = result_valid && !result_ready;
    result_next       = result;
    item_ready        = 1'b0;
    sort_ctrl         = '0;
    div_start         = 1'b0;
    emit_addr         = idx[AW-1:0];
    load_result       = 1'b0;
    case (state)
      sas_pkg::ST_COLLECT: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (count != CW'(MAX_SCORES)) begin
            sort_ctrl.load = 1'b1;
            count_next     = count + CW'(1);
            sum_next       = sum + SW'(item.score);
          end else begin
            dropped_next = 1'b1;
          end
          if (item.last) begin
            state_next = sas_pkg::ST_START;
          end
        end
      end
      sas_pkg::ST_START: begin
        sort_ctrl.start = 1'b1;
        div_start       = 1'b1;
        idx_next        = '0;
        state_next      = sas_pkg::ST_WAIT;
      end
      sas_pkg::ST_WAIT: begin
        if (!sort_busy && !div_busy) begin
          state_next = sas_pkg::ST_READ;
        end
      end
      sas_pkg::ST_READ: begin
        state_next = sas_pkg::ST_LOAD;
      end
      sas_pkg::ST_LOAD: begin
        // read data stays put while the output register is stalled
        if (!result_valid || result_ready) begin
          load_result              = 1'b1;
          result_valid_next        = 1'b1;
          result_next.sorted_score = rd_data;
          result_next.average      = quotient;
          result_next.overflow     = dropped;
          result_next.end_of_run   = (idx + CW'(1)) == count;
          if ((idx + CW'(1)) == count) begin
            count_next   = '0;
            sum_next     = '0;
            dropped_next = 1'b0;
            state_next   = sas_pkg::ST_COLLECT;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = sas_pkg::ST_READ;
          end
        end
      end
      default: state_next = sas_pkg::ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sas_pkg::ST_COLLECT;
      count        <= '0;
      sum          <= '0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      sum          <= sum_next;
      dropped      <= dropped_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    result <= result_next;
  end

  // a dropped score is only possible with a full store
  assert property (@(posedge clk) disable iff (rst)
    dropped |-> count == CW'(MAX_SCORES))
    else $error("overflow flagged while store not full");

  // emission never starts before sort and mean are both finished
  assert property (@(posedge clk) disable iff (rst)
    (state == sas_pkg::ST_READ) |-> (!sort_busy && !div_busy))
    else $error("readout started while sort or divide still running");

  // the final result of a set clears the set state
  assert property (@(posedge clk) disable iff (rst)
    (load_result && result_next.end_of_run) |=>
      (state == sas_pkg::ST_COLLECT && count == '0 && sum == '0 && !dropped))
    else $error("set state not cleared after final result");

  // a set never closes empty
  assert property (@(posedge clk) disable iff (rst)
    (state == sas_pkg::ST_START) |-> count != '0)
    else $error("set closed with no stored score");

  // a stalled result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !load_result)
    else $error("pending result overwritten");

endmodule
